FILE: hw/rtl/fbpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpe_pkg - shared definitions for the frame byte pixel expander
// Format register bits, raster constants, palette lookups and the group type.
// ----------------------------------------------------------------------------
package fbpe_pkg;

	// Raster geometry: FRAME_SIDE x FRAME_SIDE pixels, grouped 2x2.
	localparam int FRAME_SIDE = 128;
	localparam int COORD_W    = $clog2(FRAME_SIDE);

	// Item field widths.
	localparam int OFFSET_W = 11;
	localparam int BYTE_W   = 8;
	localparam int FMT_W    = 8;
	localparam int COLOR_W  = 16;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 3;

	// Packed stream widths, rounded up to whole bytes.
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 80;

	// Format register bit positions.
	localparam int FMT_COLOR = 4;
	localparam int FMT_LARGE = 5;
	localparam int FMT_HIRES = 6;

	// Group counter codes at which a byte is finished.
	localparam logic [CNT_W-1:0] CNT_LAST_LARGE = 3'd1;
	localparam logic [CNT_W-1:0] CNT_LAST_SMALL = 3'd7;

	localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

	// One 2x2 pixel group as it leaves the expander.
	typedef struct packed {
		logic               last;
		logic [COLOR_W-1:0] br;
		logic [COLOR_W-1:0] bl;
		logic [COLOR_W-1:0] tr;
		logic [COLOR_W-1:0] tl;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} grp_t;

	// RGB565 color palette.
	function automatic logic [COLOR_W-1:0] pal_color(input logic [IDX_W-1:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			4'd0:    c = 16'h0000;
			4'd1:    c = 16'h8000;
			4'd2:    c = 16'h0400;
			4'd3:    c = 16'h8400;
			4'd4:    c = 16'h0010;
			4'd5:    c = 16'h8010;
			4'd6:    c = 16'h0410;
			4'd7:    c = 16'h8410;
			4'd8:    c = 16'h0000;
			4'd9:    c = 16'hf800;
			4'd10:   c = 16'h07e0;
			4'd11:   c = 16'hffe0;
			4'd12:   c = 16'h001f;
			4'd13:   c = 16'hf81f;
			4'd14:   c = 16'h07ff;
			default: c = 16'hffff;
		endcase
		return c;
	endfunction

	// RGB565 gray ramp.
	function automatic logic [COLOR_W-1:0] pal_gray(input logic [IDX_W-1:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			4'd0:    c = 16'h0000;
			4'd1:    c = 16'h1082;
			4'd2:    c = 16'h2104;
			4'd3:    c = 16'h31a6;
			4'd4:    c = 16'h4228;
			4'd5:    c = 16'h52aa;
			4'd6:    c = 16'h632c;
			4'd7:    c = 16'h73ae;
			4'd8:    c = 16'h8c51;
			4'd9:    c = 16'h9cd3;
			4'd10:   c = 16'had55;
			4'd11:   c = 16'hbdd7;
			4'd12:   c = 16'hce59;
			4'd13:   c = 16'hdefb;
			4'd14:   c = 16'hef7d;
			default: c = 16'hffff;
		endcase
		return c;
	endfunction

	// Palette selected by the color bit of the format register.
	function automatic logic [COLOR_W-1:0] pal_lookup(input logic use_color,
	                                                  input logic [IDX_W-1:0] idx);
		return use_color ? pal_color(idx) : pal_gray(idx);
	endfunction

endpackage

FILE: hw/rtl/frame_byte_pixel_expander_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_pixel_expander_top - display byte to 2x2 pixel group expander
// Turns one display memory byte and its frame offset into RGB565 pixel groups.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests on s_* carry {memory_byte, byte_offset}. Each byte produces
//   two groups in quadrant layout or eight groups in 512-byte layout, sent as
//   output requests on m_* one per cycle while m_tready is high; m_tlast
//   marks a byte's final group. The user must write the format register
//   (cfg_we / cfg_wdata) only while no byte is in flight; the block does not
//   enforce this. Each byte keeps the format it was accepted with.
// Throughput: one group per cycle while m_tready is high, set by the single
//   group generator. A byte is held in the input stage; each of its groups is
//   registered in the output register before reaching m_*. The next byte is
//   accepted in the cycle the previous byte's last group moves there, so no gap.
// Reset: arst_n clears the format register to 0 and empties both stages.
// Stall: when m_tready is low the output register holds its group, the held
//   byte stops advancing and s_tready drops until the output moves again.
// ----------------------------------------------------------------------------
module frame_byte_pixel_expander_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Format register write.
	input  logic                          cfg_we,
	input  logic [fbpe_pkg::FMT_W-1:0]    cfg_wdata,
	// Byte requests.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fbpe_pkg::S_DATA_W-1:0] s_tdata,  // byte_offset[10:0], memory_byte[18:11]
	// Group requests.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbpe_pkg::M_DATA_W-1:0] m_tdata,  // group_x[6:0], group_y[13:7],
	                                                // color_top_left[29:14],
	                                                // color_top_right[45:30],
	                                                // color_bottom_left[61:46],
	                                                // color_bottom_right[77:62]
	output logic                          m_tlast   // last_group
);
	import fbpe_pkg::*;

	logic [FMT_W-1:0]    fmt_q;
	logic                valid_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic [FMT_W-1:0]    fmt_s1;
	logic [CNT_W-1:0]    cnt_q;
	logic                valid_s2;
	grp_t                grp_s2;
	grp_t                grp;
	logic                out_free;
	logic                grp_fire;
	logic                in_fire;

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= '0;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	assign out_free = !valid_s2 || m_tready;
	assign grp_fire = valid_s1 && out_free;
	assign s_tready = !valid_s1 || (grp_fire && grp.last);
	assign in_fire  = s_tvalid && s_tready;

	// Input stage: holds the byte while its groups are generated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				cnt_q    <= '0;
			end else if (grp_fire) begin
				if (grp.last) begin
					valid_s1 <= 1'b0;
					cnt_q    <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			off_s1  <= s_tdata[OFFSET_W-1:0];
			byte_s1 <= s_tdata[OFFSET_W +: BYTE_W];
			fmt_s1  <= fmt_q;
		end
	end

	fbpe_group u_group (
		.byte_offset (off_s1),
		.memory_byte (byte_s1),
		.fmt         (fmt_s1),
		.cnt         (cnt_q),
		.grp         (grp)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_fire) begin
			grp_s2 <= grp;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = grp_s2.last;
	assign m_tdata  = {2'b00, grp_s2.br, grp_s2.bl, grp_s2.tr, grp_s2.tl,
	                   grp_s2.y, grp_s2.x};

	// Quadrant layout never counts past its second group.
	a_large_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fmt_s1[FMT_LARGE]) |-> (cnt_q <= CNT_LAST_LARGE))
		else $error("group counter ran past quadrant layout end");

	// An empty input stage has its counter parked at zero.
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (cnt_q == '0))
		else $error("group counter not cleared while idle");

	// After a byte's last group leaves with no new byte, the stage empties.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_fire && grp.last && !in_fire) |=> !valid_s1)
		else $error("input stage still busy after last group");

	// Group coordinates are always even.
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == 1'b0 && m_tdata[COORD_W] == 1'b0))
		else $error("odd group coordinate");

endmodule

FILE: hw/rtl/fbpe_group.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpe_group - one 2x2 pixel group from a held byte
// Works out position, four colors and the last flag for group number cnt.
// ----------------------------------------------------------------------------
module fbpe_group (
	input  logic [fbpe_pkg::OFFSET_W-1:0] byte_offset,
	input  logic [fbpe_pkg::BYTE_W-1:0]   memory_byte,
	input  logic [fbpe_pkg::FMT_W-1:0]    fmt,
	input  logic [fbpe_pkg::CNT_W-1:0]    cnt,
	output fbpe_pkg::grp_t                grp
);
	import fbpe_pkg::*;

	logic               quad_mode;
	logic [IDX_W-1:0]   bits;
	logic [COLOR_W-1:0] fg;
	logic [COLOR_W-1:0] fill;
	logic [COLOR_W-1:0] col [4];

	assign quad_mode = fmt[FMT_LARGE];

	// Even groups use the low nibble (pattern A), odd groups the high nibble.
	assign bits = cnt[0] ? memory_byte[7:4] : memory_byte[3:0];
	assign fg   = pal_lookup(fmt[FMT_COLOR], fmt[IDX_W-1:0]);
	assign fill = pal_lookup(fmt[FMT_COLOR], bits);

	// High resolution: one bit per pixel, foreground or black; else the nibble's color.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (fmt[FMT_HIRES]) begin
				col[k] = bits[k] ? fg : COLOR_BLACK;
			end else begin
				col[k] = fill;
			end
		end
	end

	// Position: quadrant layout yields a left and right group, the small
	// layout two rows of four groups over an 8 x 4 pixel block.
	always_comb begin
		grp.tl = col[0];
		grp.tr = col[1];
		grp.bl = col[2];
		grp.br = col[3];
		if (quad_mode) begin
			grp.x    = {byte_offset[9], byte_offset[3:0], cnt[0], 1'b0};
			grp.y    = {byte_offset[10], byte_offset[8:4], 1'b0};
			grp.last = (cnt == CNT_LAST_LARGE);
		end else begin
			grp.x    = {byte_offset[3:0], cnt[1:0], 1'b0};
			grp.y    = {byte_offset[8:4], cnt[2], 1'b0};
			grp.last = (cnt == CNT_LAST_SMALL);
		end
	end

endmodule

FILE: tb/frame_byte_pixel_expander_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_pixel_expander_checker - pixel group predictor and comparator
// Follows the format register writes and every accepted byte request,
// expands each byte into the 2x2 groups it must produce, and compares every
// accepted group request field by field with the oldest pending group.
// ----------------------------------------------------------------------------
module frame_byte_pixel_expander_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbpe_pkg::FMT_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [fbpe_pkg::S_DATA_W-1:0] s_tdata,  // byte_offset[10:0], memory_byte[18:11]
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [fbpe_pkg::M_DATA_W-1:0] m_tdata,  // group_x[6:0], group_y[13:7],
	                                                // color_top_left[29:14],
	                                                // color_top_right[45:30],
	                                                // color_bottom_left[61:46],
	                                                // color_bottom_right[77:62]
	input  logic                          m_tlast,  // last_group
	output int                            fail_count,
	output int                            groups_pending
);

	import fbpe_pkg::*;

	typedef struct packed {
		logic [6:0]  x;
		logic [6:0]  y;
		logic [15:0] tl;
		logic [15:0] tr;
		logic [15:0] bl;
		logic [15:0] br;
		logic        last;
	} pixel_group_t;

	// Groups still owed by the block, oldest first.
	pixel_group_t expected_groups[$];
	logic [FMT_W-1:0] format_shadow;
	pixel_group_t seen_group;
	pixel_group_t want_group;

	// RGB565 value for a palette index; the upper select bit picks color over gray.
	function automatic logic [15:0] rgb565_of(input logic use_color, input logic [3:0] idx);
		logic [15:0] c;
		case ({use_color, idx})
			5'h00: c = 16'h0000;
			5'h01: c = 16'h1082;
			5'h02: c = 16'h2104;
			5'h03: c = 16'h31a6;
			5'h04: c = 16'h4228;
			5'h05: c = 16'h52aa;
			5'h06: c = 16'h632c;
			5'h07: c = 16'h73ae;
			5'h08: c = 16'h8c51;
			5'h09: c = 16'h9cd3;
			5'h0a: c = 16'had55;
			5'h0b: c = 16'hbdd7;
			5'h0c: c = 16'hce59;
			5'h0d: c = 16'hdefb;
			5'h0e: c = 16'hef7d;
			5'h0f: c = 16'hffff;
			5'h10: c = 16'h0000;
			5'h11: c = 16'h8000;
			5'h12: c = 16'h0400;
			5'h13: c = 16'h8400;
			5'h14: c = 16'h0010;
			5'h15: c = 16'h8010;
			5'h16: c = 16'h0410;
			5'h17: c = 16'h8410;
			5'h18: c = 16'h0000;
			5'h19: c = 16'hf800;
			5'h1a: c = 16'h07e0;
			5'h1b: c = 16'hffe0;
			5'h1c: c = 16'h001f;
			5'h1d: c = 16'hf81f;
			5'h1e: c = 16'h07ff;
			default: c = 16'hffff;
		endcase
		return c;
	endfunction

	// Expands one byte under the current format into its groups.
	function automatic void expand_byte(input logic [10:0] off, input logic [7:0] val);
		logic [15:0] pat_a [4];
		logic [15:0] pat_b [4];
		logic [15:0] fg;
		logic [6:0] base_x;
		logic [6:0] base_y;
		pixel_group_t g;
		fg = rgb565_of(format_shadow[FMT_COLOR], format_shadow[3:0]);
		for (int k = 0; k < 4; k++) begin
			if (format_shadow[FMT_HIRES]) begin
				pat_a[k] = val[k] ? fg : 16'h0000;
				pat_b[k] = val[4 + k] ? fg : 16'h0000;
			end else begin
				pat_a[k] = rgb565_of(format_shadow[FMT_COLOR], val[3:0]);
				pat_b[k] = rgb565_of(format_shadow[FMT_COLOR], val[7:4]);
			end
		end
		if (format_shadow[FMT_LARGE]) begin
			// Quadrant layout: two groups side by side, A then B.
			base_x = {off[9], off[3:0], 2'b00};
			base_y = {off[10], off[8:4], 1'b0};
			for (int h = 0; h < 2; h++) begin
				g.x    = base_x + 7'(2 * h);
				g.y    = base_y;
				g.tl   = h ? pat_b[0] : pat_a[0];
				g.tr   = h ? pat_b[1] : pat_a[1];
				g.bl   = h ? pat_b[2] : pat_a[2];
				g.br   = h ? pat_b[3] : pat_a[3];
				g.last = (h == 1);
				expected_groups.push_back(g);
			end
		end else begin
			// 512-byte layout: an 8x4 block, row by row, patterns alternating.
			base_x = {off[3:0], 3'b000};
			base_y = {off[8:4], 2'b00};
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 4; c++) begin
					g.x    = base_x + 7'(2 * c);
					g.y    = base_y + 7'(2 * r);
					g.tl   = c[0] ? pat_b[0] : pat_a[0];
					g.tr   = c[0] ? pat_b[1] : pat_a[1];
					g.bl   = c[0] ? pat_b[2] : pat_a[2];
					g.br   = c[0] ? pat_b[3] : pat_a[3];
					g.last = (r == 1 && c == 3);
					expected_groups.push_back(g);
				end
			end
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
	                                    input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Byte requests are predicted with the format in force before any write at
	// the same edge; group requests are compared against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_shadow = '0;
			expected_groups.delete();
			fail_count = 0;
			groups_pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				expand_byte(s_tdata[10:0], s_tdata[18:11]);
			if (cfg_we)
				format_shadow = cfg_wdata;
			if (m_tvalid && m_tready) begin
				seen_group = {m_tdata[6:0], m_tdata[13:7], m_tdata[29:14], m_tdata[45:30],
				              m_tdata[61:46], m_tdata[77:62], m_tlast};
				if (expected_groups.size() == 0) begin
					$error("unexpected group request: x=%0d y=%0d",
					       seen_group.x, seen_group.y);
					fail_count++;
				end else begin
					want_group = expected_groups.pop_front();
					check_field("group_x", want_group.x, seen_group.x);
					check_field("group_y", want_group.y, seen_group.y);
					check_field("color_top_left", want_group.tl, seen_group.tl);
					check_field("color_top_right", want_group.tr, seen_group.tr);
					check_field("color_bottom_left", want_group.bl, seen_group.bl);
					check_field("color_bottom_right", want_group.br, seen_group.br);
					check_field("last_group", want_group.last, seen_group.last);
				end
			end
			groups_pending = expected_groups.size();
		end
	end

endmodule

FILE: tb/frame_byte_pixel_expander_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_pixel_expander_top_test - stimulus and verdict for the expander
// Writes a series of display formats, feeds directed and random byte requests
// with random gaps and output stalls, including one long output hold, and
// reports the result of the attached checker.
// ----------------------------------------------------------------------------
module frame_byte_pixel_expander_top_test;

	import fbpe_pkg::*;

	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 14;
	localparam int LONG_HOLD       = 300;
	localparam int DRAIN_CYCLES    = 20;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [FMT_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	int                  fail_count;
	int                  groups_pending;

	// Idling controls for the sender and the receiver, set by the stimulus.
	bit send_gaps;
	bit recv_gaps;
	bit long_hold_req;

	frame_byte_pixel_expander_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	frame_byte_pixel_expander_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.groups_pending(groups_pending)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: an optional random stall before each group, and one long hold.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end
			stall = recv_gaps ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one byte request after an optional gap and waits for acceptance.
	task automatic send_byte(input logic [10:0] off, input logic [7:0] val);
		int gap;
		gap = send_gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, val, off};
		do @(posedge clk); while (!s_tready);
	endtask

	// Lets the block drain completely, then writes the format register.
	task automatic set_format(input logic [FMT_W-1:0] value);
		@(negedge clk) s_tvalid <= 1'b0;
		while (groups_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Stimulus and verdict.
	initial begin
		logic [FMT_W-1:0] fmt;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		long_hold_req = 1'b0;
		arst_n    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset format: gray, 512-byte layout, low resolution.
		send_byte(11'h000, 8'h00);
		send_byte(11'h7ff, 8'hff);
		send_byte(11'h1ff, 8'ha5);
		// High resolution, quadrants, color, black foreground.
		set_format(8'h70);
		send_byte(11'h000, 8'hff);
		send_byte(11'h7ff, 8'h5a);
		// Every bit set, including the ignored top bit; all four quadrants.
		set_format(8'hff);
		send_byte(11'h000, 8'hff);
		send_byte(11'h7ff, 8'h00);
		send_byte(11'h200, 8'h96);
		send_byte(11'h400, 8'h69);
		// Low resolution quadrants in gray: the foreground bits have no effect.
		set_format(8'h2f);
		send_byte(11'h5a5, 8'h0f);
		send_byte(11'h3ff, 8'hf0);
		// High resolution, 512-byte layout, gray foreground.
		set_format(8'h4b);
		send_byte(11'h000, 8'hff);
		send_byte(11'h7ff, 8'h81);
		// Low resolution color, 512-byte layout, offset bits above 8 ignored.
		set_format(8'h10);
		send_byte(11'h123, 8'he1);
		send_byte(11'h723, 8'h8f);
		// Only the ignored top bit set.
		set_format(8'h80);
		send_byte(11'h000, 8'h3c);

		// Random phases: each forces a layout and resolution mix.
		for (int phase = 0; phase < PHASES; phase++) begin
			fmt = FMT_W'($urandom_range(0, 255));
			fmt[FMT_LARGE] = phase[0];
			fmt[FMT_HIRES] = phase[1];
			set_format(fmt);
			send_gaps = (phase % 3) != 0;
			recv_gaps = (phase % 4) != 1;
			// One phase holds the output off while bytes keep coming.
			if (phase == 2) begin
				send_gaps = 1'b0;
				long_hold_req = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_byte(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
		end

		@(negedge clk) s_tvalid <= 1'b0;
		while (groups_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && groups_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: frame_byte_pixel_expander_top.f
hw/rtl/fbpe_pkg.sv
hw/rtl/fbpe_group.sv
hw/rtl/frame_byte_pixel_expander_top.sv
tb/frame_byte_pixel_expander_checker.sv
tb/frame_byte_pixel_expander_top_test.sv
